/* design/rmsp_pkg.sv */
// Package: command/status codes and beat structs for the read memory size profiler.
`default_nettype none
package rmsp_pkg;
  localparam logic [1:0] CMD_CALL   = 2'd0;
  localparam logic [1:0] CMD_RETURN = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_WRITE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EXHAUST  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] word_address;
    logic [6:0]  word_count;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] frame_size;
    logic [5:0]         depth;
  } out_beat_t;

  // Control broadcast from the sequencer to every frame cell.
  typedef struct packed {
    logic        push;       // new frame at top+1
    logic        pop;        // fold top into top-1
    logic        inc_top;    // count a first access in the top frame
    logic        dec_en;     // debit the deepest frame with stamp <= key
    logic [31:0] key;        // word stamp used for the debit search
    logic [31:0] stamp;      // stamp for a pushed frame
  } cell_ctl_t;
endpackage
`default_nettype wire

/* design/rmsp_cell.sv */
// One shadow frame cell: stamp, read count, and its link in the search chain.
`default_nettype none
module rmsp_cell #(
  parameter int IDX_BITS = 6,
  parameter int IDX      = 0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire rmsp_pkg::cell_ctl_t ctl,
  input  wire  [IDX_BITS-1:0]   top,
  // fold from the cell above on a return
  input  wire  [31:0]           reads_above,
  // true if some deeper-above active cell already matched the search
  input  wire                   found_above,
  output logic                  found_out,
  output logic [31:0]           reads,
  output logic [31:0]           stamp
);
  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

  logic active, match, hit;

  // Active frames are those at or below the top of stack.
  assign active    = (MY_IDX <= top);
  assign match     = active && (stamp <= ctl.key);
  assign hit       = match && !found_above;
  assign found_out = found_above || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      reads <= '0;
      stamp <= '0;
    end else if (ctl.push && (MY_IDX == top + 1'b1)) begin
      stamp <= ctl.stamp;
      reads <= '0;
    end else if (ctl.pop && (MY_IDX + 1'b1 == top)) begin
      reads <= reads + reads_above;
    end else begin
      reads <= reads + {31'd0, (ctl.inc_top && MY_IDX == top)}
                     - {31'd0, (ctl.dec_en && hit)};
    end
  end
endmodule
`default_nettype wire

/* design/read_memory_size_profiler_unit.sv */
// Top level: sequencer, shadow word stamp memory and the chain of frame cells.
//
//  channel | ports                   | handshake
//  --------+-------------------------+----------------------------------
//  command | start, busy, in_beat    | taken when start && !busy
//  result  | done, out_beat          | one cycle on done, cannot stall
//
// Call and return go from accept straight to the done state. A read or write
// range steps each word through memory read, check and update states, for
// up to MAX_RANGE words. After reset the word stamp memory is cleared, one
// word per cycle, over all 2^ADDR_BITS words with busy high. The frame search
// runs as a combinational priority chain through the cells, top down.
`default_nettype none
module read_memory_size_profiler_unit #(
  parameter int ADDR_BITS   = 16,
  parameter int STACK_DEPTH = 64,
  parameter int MAX_RANGE   = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire rmsp_pkg::in_beat_t in_beat,
  output logic                 busy,
  output logic                 done,
  output rmsp_pkg::out_beat_t  out_beat
);
  localparam int IDX_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int WORDS    = 1 << ADDR_BITS;
  localparam int CNT_BITS = $clog2(MAX_RANGE + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state;
  logic [1:0]           cmd;
  logic [ADDR_BITS-1:0] addr;
  logic [CNT_BITS-1:0]  left;
  logic [IDX_BITS-1:0]  top;
  logic [31:0]          call_counter;
  logic [1:0]           status;
  logic                 size_from_ret;
  logic [31:0]          ret_size;
  logic [31:0]          wstamp_q;
  logic [ADDR_BITS-1:0] clr_addr;

  logic [31:0] mem [WORDS];

  rmsp_pkg::cell_ctl_t ctl;
  logic [31:0] reads [STACK_DEPTH];
  logic [31:0] stamps[STACK_DEPTH];
  logic        found [STACK_DEPTH+1];

  // Frame cell chain; the search priority flows from the deepest cell down.
  assign found[STACK_DEPTH] = 1'b0;
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [31:0] above;
    if (i == STACK_DEPTH - 1) begin : g_last
      assign above = '0;
    end else begin : g_mid
      assign above = reads[i+1];
    end
    rmsp_cell #(.IDX_BITS(IDX_BITS), .IDX(i)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .top(top),
      .reads_above(above), .found_above(found[i+1]),
      .found_out(found[i]), .reads(reads[i]), .stamp(stamps[i])
    );
  end

  logic [CNT_BITS-1:0] cnt_sat;
  assign cnt_sat = (32'(in_beat.word_count) > 32'(MAX_RANGE)) ? CNT_BITS'(MAX_RANGE)
                                                              : CNT_BITS'(in_beat.word_count);
  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  logic first_acc;
  assign first_acc = (wstamp_q < stamps[top]);

  // Broadcast control to the cells.
  always_comb begin
    ctl = '0;
    ctl.key   = wstamp_q;
    ctl.stamp = call_counter + 32'd1;
    if (accept && in_beat.command == rmsp_pkg::CMD_CALL &&
        top != IDX_BITS'(STACK_DEPTH - 1) && call_counter != '1)
      ctl.push = 1'b1;
    if (accept && in_beat.command == rmsp_pkg::CMD_RETURN && top != '0)
      ctl.pop = 1'b1;
    if (state == S_CHK && cmd == rmsp_pkg::CMD_READ && first_acc) begin
      ctl.inc_top = 1'b1;
      ctl.dec_en  = (wstamp_q != '0);
    end
  end

  // Shadow word memory: clear sweep, one read port, one write port.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR)
      mem[clr_addr] <= '0;
    else if (state == S_UPD)
      mem[addr] <= call_counter;
    wstamp_q <= mem[addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      top          <= '0;
      call_counter <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_BITS'(WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          cmd           <= in_beat.command;
          addr          <= ADDR_BITS'(in_beat.word_address);
          left          <= cnt_sat;
          status        <= rmsp_pkg::ST_OK;
          size_from_ret <= 1'b0;
          state         <= S_DONE;
          case (in_beat.command)
            rmsp_pkg::CMD_CALL: begin
              if (top == IDX_BITS'(STACK_DEPTH - 1)) status <= rmsp_pkg::ST_FULL;
              else if (call_counter == '1) status <= rmsp_pkg::ST_EXHAUST;
              else begin
                call_counter <= call_counter + 32'd1;
                top          <= top + 1'b1;
              end
            end
            rmsp_pkg::CMD_RETURN: begin
              if (top == '0) status <= rmsp_pkg::ST_EMPTY;
              else begin
                size_from_ret <= 1'b1;
                ret_size      <= reads[top];
                top           <= top - 1'b1;
              end
            end
            default: if (cnt_sat != '0) state <= S_RD;
          endcase
        end
        S_RD:  state <= S_CHK;
        S_CHK: state <= S_UPD;
        S_UPD: begin
          addr  <= addr + 1'b1;
          left  <= left - 1'b1;
          state <= (left == CNT_BITS'(1)) ? S_DONE : S_RD;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result beat.
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      out_beat.status     <= status;
      out_beat.frame_size <= size_from_ret ? ret_size : reads[top];
      out_beat.depth      <= 6'(top);
    end
  end
endmodule
`default_nettype wire
